[rtl/core/tpc_pkg.sv]
package tpc_pkg;

  // register stages from input capture to the output register
  localparam int NST = 13;

  // configuration register byte addresses
  localparam logic [2:0] ADDR_DIST = 3'd0;
  localparam logic [2:0] ADDR_NORM = 3'd4;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by_coord;
    coord_t bz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
    coord_t px;
    coord_t py;
    coord_t pz;
  } item_t;

  typedef enum logic [1:0] {
    POS_UP   = 2'd0,
    POS_DOWN = 2'd1,
    POS_ON   = 2'd2,
    POS_NONE = 2'd3
  } pos_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // per-stage capture enables, index = stage number
  typedef logic [NST:1] stage_en_t;

endpackage

[rtl/core/triangle_point_containment.sv]
// 13 register stages run from input capture to the output register.
// Throughput: one word per cycle while the output is not stalled; the fixed
// 13-stage pipeline sets the figure, with the leading-one search and the
// tolerance products each split over stages.
// Stalls back up stage by stage; empty stages keep filling under a held output.
// Reset (rst, synchronous, active high) empties the pipeline and sets both
// tolerance registers to 1.
module triangle_point_containment (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] az,
  input  logic signed [31:0] bx,
  input  logic signed [31:0] by_coord,
  input  logic signed [31:0] bz,
  input  logic signed [31:0] cx,
  input  logic signed [31:0] cy,
  input  logic signed [31:0] cz,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        contains,
  output logic [1:0]  projection_axis,
  output logic [1:0]  edge_ab,
  output logic [1:0]  edge_bc,
  output logic [1:0]  edge_ca
);

  localparam int NST = tpc_pkg::NST;

  // register select is address bit 2
  localparam logic REG_DIST = 1'b0;
  localparam logic REG_NORM = 1'b1;

  logic [15:0] dist_tol, norm_tol;

  tpc_pkg::item_t item_in, item3, item10;
  logic [2:0][65:0] mag;
  tpc_pkg::axis_t axis10, axis12;
  tpc_pkg::pos_t [2:0] pos;

  logic [NST:1] vld;
  logic [NST:1] go;
  tpc_pkg::stage_en_t en;

  tpc_pkg::pos_t pos_ab, pos_bc, pos_ca;
  tpc_pkg::axis_t axis_q;
  logic contains_q;
  logic up_any, down_any, on_any;

  // ---------------- configuration ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_tol <= 16'd1;
      norm_tol <= 16'd1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_DIST: dist_tol <= pwdata[15:0];
        REG_NORM: norm_tol <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DIST: prdata = {16'b0, dist_tol};
      REG_NORM: prdata = {16'b0, norm_tol};
      default:  prdata = 32'b0;
    endcase
  end

  // ---------------- flow control ----------------
  // A stage captures when it is empty or the stage after it captures too,
  // so bubbles collapse while the output word is held.
  always_comb begin
    go[NST] = !vld[NST] || !out_stall;
    for (int i = NST - 1; i >= 1; i--) go[i] = !vld[i] || go[i+1];
  end

  assign en       = go;
  assign in_stall = !go[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (go[1]) vld[1] <= in_valid;
      for (int i = 2; i <= NST; i++) begin
        if (go[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // ---------------- datapath ----------------
  assign item_in = '{ax: ax, ay: ay, az: az, bx: bx, by_coord: by_coord, bz: bz,
                     cx: cx, cy: cy, cz: cz, px: px, py: py, pz: pz};

  // stages 1-3: face normal magnitudes
  tpc_normal u_normal (
    .clk      (clk),
    .en       (en),
    .item_in  (item_in),
    .item_out (item3),
    .mag      (mag)
  );

  // stages 4-10: scale, square and pick the dropped axis
  tpc_axis u_axis (
    .clk      (clk),
    .en       (en),
    .item_in  (item3),
    .mag      (mag),
    .norm_tol (norm_tol),
    .item_out (item10),
    .axis     (axis10)
  );

  // stages 11-12: edge classification in the projected plane
  tpc_edge u_edge (
    .clk      (clk),
    .en       (en),
    .item_in  (item10),
    .axis     (axis10),
    .dist_tol (dist_tol),
    .axis_out (axis12),
    .pos      (pos)
  );

  assign up_any   = (pos[0] == tpc_pkg::POS_UP) || (pos[1] == tpc_pkg::POS_UP) ||
                    (pos[2] == tpc_pkg::POS_UP);
  assign down_any = (pos[0] == tpc_pkg::POS_DOWN) || (pos[1] == tpc_pkg::POS_DOWN) ||
                    (pos[2] == tpc_pkg::POS_DOWN);
  assign on_any   = (pos[0] == tpc_pkg::POS_ON) || (pos[1] == tpc_pkg::POS_ON) ||
                    (pos[2] == tpc_pkg::POS_ON);

  // stage 13: output word
  always_ff @(posedge clk) begin
    if (en[NST]) begin
      pos_ab     <= pos[0];
      pos_bc     <= pos[1];
      pos_ca     <= pos[2];
      axis_q     <= axis12;
      contains_q <= (up_any && down_any) || on_any;
    end
  end

  assign out_valid       = vld[NST];
  assign contains        = contains_q;
  assign projection_axis = axis_q;
  assign edge_ab         = pos_ab;
  assign edge_bc         = pos_bc;
  assign edge_ca         = pos_ca;

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[1])
    else $error("accepted word did not enter stage 1");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> vld[1])
    else $error("input stalled with stage 1 empty");

  a_contains_rule: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (contains ==
      (((edge_ab == 2'(tpc_pkg::POS_UP)) || (edge_bc == 2'(tpc_pkg::POS_UP)) ||
        (edge_ca == 2'(tpc_pkg::POS_UP))) &&
       ((edge_ab == 2'(tpc_pkg::POS_DOWN)) || (edge_bc == 2'(tpc_pkg::POS_DOWN)) ||
        (edge_ca == 2'(tpc_pkg::POS_DOWN))) ||
       (edge_ab == 2'(tpc_pkg::POS_ON)) || (edge_bc == 2'(tpc_pkg::POS_ON)) ||
       (edge_ca == 2'(tpc_pkg::POS_ON)))))
    else $error("contains disagrees with edge results");
`endif

endmodule

[rtl/core/tpc_normal.sv]
module tpc_normal (
  input  logic               clk,
  input  tpc_pkg::stage_en_t en,
  input  tpc_pkg::item_t     item_in,
  output tpc_pkg::item_t     item_out,
  output logic [2:0][65:0]   mag
);

  tpc_pkg::item_t s1_item, s2_item;
  logic signed [32:0] e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [65:0] p0, p1, p2, p3, p4, p5;
  logic signed [66:0] nx, ny, nz;

  // stage 1: edge vectors b-a, c-a
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_item <= item_in;
      e1x <= 33'(item_in.bx) - 33'(item_in.ax);
      e1y <= 33'(item_in.by_coord) - 33'(item_in.ay);
      e1z <= 33'(item_in.bz) - 33'(item_in.az);
      e2x <= 33'(item_in.cx) - 33'(item_in.ax);
      e2y <= 33'(item_in.cy) - 33'(item_in.ay);
      e2z <= 33'(item_in.cz) - 33'(item_in.az);
    end
  end

  // stage 2: cross product terms
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_item <= s1_item;
      p0 <= e1y * e2z;
      p1 <= e1z * e2y;
      p2 <= e1z * e2x;
      p3 <= e1x * e2z;
      p4 <= e1x * e2y;
      p5 <= e1y * e2x;
    end
  end

  assign nx = 67'(p0) - 67'(p1);
  assign ny = 67'(p2) - 67'(p3);
  assign nz = 67'(p4) - 67'(p5);

  // stage 3: normal magnitudes
  always_ff @(posedge clk) begin
    if (en[3]) begin
      item_out <= s2_item;
      mag[0] <= nx[66] ? 66'(-nx) : 66'(nx);
      mag[1] <= ny[66] ? 66'(-ny) : 66'(ny);
      mag[2] <= nz[66] ? 66'(-nz) : 66'(nz);
    end
  end

endmodule

[rtl/core/tpc_axis.sv]
module tpc_axis (
  input  logic               clk,
  input  tpc_pkg::stage_en_t en,
  input  tpc_pkg::item_t     item_in,
  input  logic [2:0][65:0]   mag,
  input  logic [15:0]        norm_tol,
  output tpc_pkg::item_t     item_out,
  output tpc_pkg::axis_t     axis
);

  localparam int CHUNKS = 6;
  localparam int CW     = 11;

  tpc_pkg::item_t s4_item, s5_item, s6_item, s7_item, s8_item, s9_item;
  logic [2:0][65:0] mag4, mag5;
  logic [CHUNKS-1:0] cnz, cnz_c;
  logic [CHUNKS-1:0][3:0] clen, clen_c;
  logic [65:0] orw;
  logic [6:0] len;
  logic [5:0] shamt, shamt_c;
  logic [29:0] m0, m1, m2;
  logic [59:0] sq0, sq1, sq2, sq0_8, sq1_8, sq0_9, sq1_9;
  logic [61:0] sum;
  logic [31:0] t2;
  logic [62:0] pp_lo, pp_hi;
  logic [93:0] rhs;
  logic take_x, take_y;

  assign orw = mag[0] | mag[1] | mag[2];

  // leading one, split into chunks
  always_comb begin
    for (int j = 0; j < CHUNKS; j++) begin
      clen_c[j] = 4'd0;
      for (int i = 0; i < CW; i++) begin
        if (orw[j*CW+i]) clen_c[j] = 4'(i + 1);
      end
      cnz_c[j] = |orw[j*CW +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_item <= item_in;
      mag4 <= mag;
      cnz <= cnz_c;
      clen <= clen_c;
    end
  end

  always_comb begin
    len = 7'd0;
    for (int j = 0; j < CHUNKS; j++) begin
      if (cnz[j]) len = 7'(j*CW) + 7'(clen[j]);
    end
    shamt_c = (len > 7'd30) ? 6'(len - 7'd30) : 6'd0;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_item <= s4_item;
      mag5 <= mag4;
      shamt <= shamt_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_item <= s5_item;
      m0 <= 30'(mag5[0] >> shamt);
      m1 <= 30'(mag5[1] >> shamt);
      m2 <= 30'(mag5[2] >> shamt);
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_item <= s6_item;
      sq0 <= m0 * m0;
      sq1 <= m1 * m1;
      sq2 <= m2 * m2;
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_item <= s7_item;
      sum <= 62'(sq0) + 62'(sq1) + 62'(sq2);
      t2 <= norm_tol * norm_tol;
      sq0_8 <= sq0;
      sq1_8 <= sq1;
    end
  end

  // tol^2 * sum in two halves
  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_item <= s8_item;
      pp_lo <= t2 * sum[30:0];
      pp_hi <= t2 * sum[61:31];
      sq0_9 <= sq0_8;
      sq1_9 <= sq1_8;
    end
  end

  assign rhs    = {pp_hi, 31'b0} + 94'(pp_lo);
  assign take_x = 94'({sq0_9, 32'b0}) > rhs;
  assign take_y = 94'({sq1_9, 32'b0}) > rhs;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      item_out <= s9_item;
      axis <= take_x ? tpc_pkg::AXIS_X : (take_y ? tpc_pkg::AXIS_Y : tpc_pkg::AXIS_Z);
    end
  end

endmodule

[rtl/core/tpc_edge.sv]
module tpc_edge (
  input  logic                  clk,
  input  tpc_pkg::stage_en_t    en,
  input  tpc_pkg::item_t        item_in,
  input  tpc_pkg::axis_t        axis,
  input  logic [15:0]           dist_tol,
  output tpc_pkg::axis_t        axis_out,
  output tpc_pkg::pos_t [2:0]   pos
);

  typedef struct packed {
    logic               ok;
    logic [32:0]        d;
    logic signed [32:0] dv1;
    logic signed [32:0] dv;
    logic signed [32:0] q;
  } prep_t;

  function automatic prep_t prep(input tpc_pkg::coord_t pu, input tpc_pkg::coord_t pv,
                                 input tpc_pkg::coord_t u1, input tpc_pkg::coord_t v1,
                                 input tpc_pkg::coord_t u2, input tpc_pkg::coord_t v2,
                                 input logic [15:0] tol);
    logic signed [32:0] du;
    prep_t r;
    du    = 33'(u2) - 33'(u1);
    r.d   = du[32] ? 33'(-du) : 33'(du);
    r.ok  = (r.d > 33'(tol)) && ((pu >= u1 && pu <= u2) || (pu <= u1 && pu >= u2));
    r.dv1 = 33'(v1) - 33'(pv);
    r.dv  = 33'(v2) - 33'(v1);
    r.q   = du[32] ? 33'(u1) - 33'(pu) : 33'(pu) - 33'(u1);
    return r;
  endfunction

  tpc_pkg::coord_t pu, pv, au, av, bu, bv, cu, cv;
  tpc_pkg::axis_t  axis11;
  prep_t prep_c [3];
  prep_t pr [3];
  logic signed [66:0] p1 [3];
  logic signed [65:0] p2 [3];
  logic [48:0] rhs [3];
  logic ok12 [3];
  logic signed [67:0] lhs [3];
  logic signed [67:0] rhs_s [3];

  // project onto the plane that drops the chosen axis
  always_comb begin
    unique case (axis)
      tpc_pkg::AXIS_X: begin
        pu = item_in.py;       pv = item_in.pz;
        au = item_in.ay;       av = item_in.az;
        bu = item_in.by_coord; bv = item_in.bz;
        cu = item_in.cy;       cv = item_in.cz;
      end
      tpc_pkg::AXIS_Y: begin
        pu = item_in.px;       pv = item_in.pz;
        au = item_in.ax;       av = item_in.az;
        bu = item_in.bx;       bv = item_in.bz;
        cu = item_in.cx;       cv = item_in.cz;
      end
      default: begin
        pu = item_in.px;       pv = item_in.py;
        au = item_in.ax;       av = item_in.ay;
        bu = item_in.bx;       bv = item_in.by_coord;
        cu = item_in.cx;       cv = item_in.cy;
      end
    endcase
    prep_c[0] = prep(pu, pv, au, av, bu, bv, dist_tol);
    prep_c[1] = prep(pu, pv, bu, bv, cu, cv, dist_tol);
    prep_c[2] = prep(pu, pv, cu, cv, au, av, dist_tol);
  end

  always_ff @(posedge clk) begin
    if (en[11]) begin
      axis11 <= axis;
      for (int e = 0; e < 3; e++) pr[e] <= prep_c[e];
    end
  end

  // cross-multiplied line test
  always_ff @(posedge clk) begin
    if (en[12]) begin
      axis_out <= axis11;
      for (int e = 0; e < 3; e++) begin
        p1[e]   <= pr[e].dv1 * $signed({1'b0, pr[e].d});
        p2[e]   <= pr[e].dv * pr[e].q;
        rhs[e]  <= dist_tol * pr[e].d;
        ok12[e] <= pr[e].ok;
      end
    end
  end

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      lhs[e]   = 68'(p1[e]) + 68'(p2[e]);
      rhs_s[e] = $signed({19'b0, rhs[e]});
      if (!ok12[e])              pos[e] = tpc_pkg::POS_NONE;
      else if (lhs[e] > rhs_s[e])  pos[e] = tpc_pkg::POS_UP;
      else if (lhs[e] < -rhs_s[e]) pos[e] = tpc_pkg::POS_DOWN;
      else                       pos[e] = tpc_pkg::POS_ON;
    end
  end

endmodule
